[rtl/node_presence_alarm_table_unit_assert.svh]
// ----------------------------------------------------------------------------
// Node presence alarm table: assertion macros
// Shorthand for the clocked assertions of the port checker.
// ----------------------------------------------------------------------------
`ifndef NODE_PRESENCE_ALARM_TABLE_UNIT_ASSERT_SVH
`define NODE_PRESENCE_ALARM_TABLE_UNIT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define NPAT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define NPAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/npat_pkg.sv]
// ----------------------------------------------------------------------------
// Node presence alarm table: package
// Shared widths, configuration indexes and the structs passed between modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package npat_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam int ID_W    = 16;
  localparam int CODE_W  = 8;
  localparam int COUNT_W = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_FAIL = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0] normal_value;
    logic [CODE_W-1:0] alarm_value;
    logic [CODE_W-1:0] fail_value;
    logic [CODE_W-1:0] alarm_fail_value;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   node_id;
    logic [CODE_W-1:0] status_code;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic [COUNT_W-1:0] active_count;
    logic [CODE_W-1:0]  verdict;
    logic [COUNT_W-1:0] registered_count;
  } result_t;

  // Handshake between the table engine and the top level.
  typedef struct packed {
    logic start;
    logic res_take;
  } core_ctl_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } core_sts_t;

endpackage

`default_nettype wire

[rtl/npat_if.sv]
// ----------------------------------------------------------------------------
// Node presence alarm table: channel interfaces
// Valid/ready channels for the incoming requests and the outgoing results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface npat_item_if import npat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [ID_W-1:0]   node_id;
  logic [CODE_W-1:0] status_code;

  modport source (output valid, output kind, output node_id, output status_code,
                  input ready);
  modport sink (input valid, input kind, input node_id, input status_code,
                output ready);
endinterface

interface npat_result_if import npat_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [COUNT_W-1:0] active_count;
  logic [CODE_W-1:0]  verdict;
  logic [COUNT_W-1:0] registered_count;

  modport source (output valid, output accepted, output active_count,
                  output verdict, output registered_count, input ready);
  modport sink (input valid, input accepted, input active_count,
                input verdict, input registered_count, output ready);
endinterface

`default_nettype wire

[rtl/npat_core.sv]
// ----------------------------------------------------------------------------
// Node presence alarm table: table engine
// Holds the node table in a synchronous memory and walks it one entry a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module npat_core import npat_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire core_ctl_t ctl,
  input  wire item_t     item,
  output      core_sts_t sts,
  output      result_t   res
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WALK   = 4'b0010,
    ST_FINISH = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [CODE_W-1:0] code;
    logic              fresh;
  } entry_t;

  state_t          state;
  item_t           req;
  logic [CW-1:0]   count;
  logic [CW-1:0]   idx;
  logic [CW-1:0]   active;
  logic            found;
  logic [AW-1:0]   slot;
  logic            alarm;
  logic            fail;
  result_t         res_reg;

  entry_t          mem [TABLE_DEPTH];
  entry_t          rd_data;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;

  logic [CW-1:0]   idx_inc;
  logic            last;
  logic            hit;
  logic            room;
  logic [CW-1:0]   count_next;
  logic [CW+4:0]   count_ext;
  logic [CW+4:0]   active_ext;
  logic [CODE_W-1:0] verdict_sel;

  assign idx_inc = idx + CW'(1);
  assign last    = (idx == count - CW'(1));
  assign hit     = (rd_data.id == req.node_id);
  assign room    = (count < DEPTH_C);
  assign rd_addr = (state == ST_WALK) ? idx_inc[AW-1:0] : '0;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = '{id: rd_data.id, code: rd_data.code, fresh: 1'b0};
    case (state)
      ST_WALK: begin
        if (req.kind && rd_data.fresh) begin
          wr_en = 1'b1;
        end
      end
      ST_FINISH: begin
        wr_data = '{id: req.node_id, code: req.status_code, fresh: 1'b1};
        if (!req.kind) begin
          if (found) begin
            wr_en   = 1'b1;
            wr_addr = slot;
          end else if (room) begin
            wr_en   = 1'b1;
            wr_addr = count[AW-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    count_next = count;
    if (!req.kind && !found && room) begin
      count_next = count + CW'(1);
    end
    if (alarm && fail) begin
      verdict_sel = cfg.alarm_fail_value;
    end else if (alarm) begin
      verdict_sel = cfg.alarm_value;
    end else if (fail) begin
      verdict_sel = cfg.fail_value;
    end else begin
      verdict_sel = cfg.normal_value;
    end
  end

  assign count_ext  = {5'd0, count_next};
  assign active_ext = {5'd0, active};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (ctl.start) begin
            state <= (count == '0) ? ST_FINISH : ST_WALK;
          end
        end
        ST_WALK: begin
          if (last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          count <= count_next;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (ctl.res_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        req    <= item;
        idx    <= '0;
        active <= '0;
        found  <= 1'b0;
        alarm  <= 1'b0;
        fail   <= 1'b0;
      end
      ST_WALK: begin
        idx <= idx_inc;
        if (!req.kind && hit) begin
          found <= 1'b1;
          slot  <= idx[AW-1:0];
        end
        if (req.kind && rd_data.fresh) begin
          active <= active + CW'(1);
          if (rd_data.code == cfg.alarm_fail_value || rd_data.code == cfg.alarm_value) begin
            alarm <= 1'b1;
          end
          if (rd_data.code == cfg.alarm_fail_value || rd_data.code == cfg.fail_value) begin
            fail <= 1'b1;
          end
        end
      end
      ST_FINISH: begin
        res_reg.registered_count <= count_ext[4:0];
        if (req.kind) begin
          res_reg.accepted     <= 1'b1;
          res_reg.active_count <= active_ext[4:0];
          res_reg.verdict      <= verdict_sel;
        end else begin
          res_reg.accepted     <= found || room;
          res_reg.active_count <= '0;
          res_reg.verdict      <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign sts.idle      = (state == ST_IDLE);
  assign sts.res_valid = (state == ST_DONE);
  assign res           = res_reg;

endmodule

`default_nettype wire

[rtl/node_presence_alarm_table_unit.sv]
// ----------------------------------------------------------------------------
// Node presence alarm table unit
// Tracks radio nodes and folds their fresh status codes into a verdict.
// ----------------------------------------------------------------------------
// A request is either a node message or a poll and gives exactly one result.
// The table sits in one synchronous memory that is walked one entry per cycle,
// so a request walks the entries in use and then has its result registered in
// the finish state; a new request is accepted once the engine is back in idle.
// One result can wait at the output while the next request is
// processed; that request then holds off further requests until the waiting
// result has been taken. The table needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module node_presence_alarm_table_unit import npat_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  npat_item_if.sink                 item,
  npat_result_if.source             result,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [CODE_W-1:0]    wr_data
);

  cfg_t      cfg;
  core_ctl_t ctl;
  core_sts_t sts;
  item_t     item_data;
  result_t   core_res;
  logic      out_valid;
  result_t   out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normal_value     <= 8'd0;
      cfg.alarm_value      <= 8'd1;
      cfg.fail_value       <= 8'd2;
      cfg.alarm_fail_value <= 8'd3;
    end else if (wr_en) begin
      case (wr_index)
        CFG_NORMAL:     cfg.normal_value     <= wr_data;
        CFG_ALARM:      cfg.alarm_value      <= wr_data;
        CFG_FAIL:       cfg.fail_value       <= wr_data;
        CFG_ALARM_FAIL: cfg.alarm_fail_value <= wr_data;
        default: begin
        end
      endcase
    end
  end

  assign item_data = '{kind: item.kind, node_id: item.node_id,
                       status_code: item.status_code};
  assign item.ready   = sts.idle;
  assign ctl.start    = item.valid && sts.idle;
  assign ctl.res_take = sts.res_valid && (!out_valid || result.ready);

  npat_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .ctl  (ctl),
    .item (item_data),
    .sts  (sts),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.res_take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_take) begin
      out_data <= core_res;
    end
  end

  assign result.valid            = out_valid;
  assign result.accepted         = out_data.accepted;
  assign result.active_count     = out_data.active_count;
  assign result.verdict          = out_data.verdict;
  assign result.registered_count = out_data.registered_count;

endmodule

`default_nettype wire

[rtl/npat_checker.sv]
// ----------------------------------------------------------------------------
// Node presence alarm table: port checker
// Watches the ports of the unit for results that the table cannot produce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "node_presence_alarm_table_unit_assert.svh"

module npat_checker import npat_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               item_valid,
  input wire logic               item_ready,
  input wire logic               res_valid,
  input wire logic               res_ready,
  input wire logic               res_accepted,
  input wire logic [COUNT_W-1:0] res_active_count,
  input wire logic [COUNT_W-1:0] res_registered_count
);

  localparam logic [COUNT_W-1:0] DEPTH_MOD = COUNT_W'(TABLE_DEPTH % 32);
  localparam bit WRAPS = (TABLE_DEPTH > 31);

  `NPAT_ASSERT_NEXT(a_one_request_at_a_time, item_valid && item_ready, !item_ready,
    "request accepted while the previous one is still in progress")

  `NPAT_ASSERT_SAME(a_reject_only_when_full, res_valid && !res_accepted,
    WRAPS || res_registered_count == DEPTH_MOD, "message rejected with room in the table")

  `NPAT_ASSERT_SAME(a_active_within_table, res_valid,
    WRAPS || (res_active_count <= res_registered_count && res_registered_count <= DEPTH_MOD),
    "result counts exceed the entries in use")

  `NPAT_ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid,
    "result withdrawn before it was taken")

endmodule

bind node_presence_alarm_table_unit npat_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_npat_checker (
  .clk                  (clk),
  .rst                  (rst),
  .item_valid           (item.valid),
  .item_ready           (item.ready),
  .res_valid            (result.valid),
  .res_ready            (result.ready),
  .res_accepted         (result.accepted),
  .res_active_count     (result.active_count),
  .res_registered_count (result.registered_count)
);

`default_nettype wire
